### rtl/dphp_pkg.sv
// Shared constants, types and arccosine table builder for the double-phase hologram pixel encoder.
package dphp_pkg;

  localparam int MAX_ROW_LENGTH = 4096;
  localparam int MAX_CELL = 64;
  localparam int ACOS_DEPTH = 1024;

  localparam int PHASE_W = 16;
  localparam int AMP_W = 16;
  localparam int FRAC_W = 15;
  localparam int CELL_CFG_W = 7;
  localparam int LEN_CFG_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 1;

  localparam int COL_W = $clog2(MAX_ROW_LENGTH);
  localparam int CELL_W = $clog2(MAX_CELL);
  localparam int ACOS_AW = $clog2(ACOS_DEPTH);
  localparam int ACOS_W = 23;
  localparam int CORDIC_STEPS = 20;
  localparam int QUARTER_TURN_24 = 4194304;
  localparam int ROUND_SHIFT = 8;

  localparam logic [AMP_W-1:0] AMP_ONE = 16'h8000;
  localparam logic [PHASE_W-1:0] HALF_TURN = 16'h8000;
  localparam logic [PHASE_W-1:0] QUARTER_TURN_16 = 16'h4000;

  localparam logic [CFG_INDEX_W-1:0] REG_CELL_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 1'd1;

  typedef logic [ACOS_W-1:0] acos_val_t;
  typedef acos_val_t even_tab_t [0:ACOS_DEPTH/2];
  typedef acos_val_t odd_tab_t [0:ACOS_DEPTH/2-1];

  localparam longint AtanSteps [0:CORDIC_STEPS-1] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
    5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  // Arccosine in units of 2^-24 turn for amplitude k / ACOS_DEPTH.
  function automatic acos_val_t acos_entry(input int k);
    longint unsigned xu;
    longint unsigned n;
    longint unsigned res;
    longint unsigned bit_v;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    xu = (longint'(k) << 30) / ACOS_DEPTH;
    if (xu > (64'd1 << 30)) begin
      xu = 64'd1 << 30;
    end
    n = (64'd1 << 60) - xu * xu;
    res = 0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    x = longint'(xu);
    y = longint'(res);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanSteps[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanSteps[i];
      end
    end
    if (z < 0) begin
      z = 0;
    end
    if (z > QUARTER_TURN_24) begin
      z = QUARTER_TURN_24;
    end
    return acos_val_t'(z);
  endfunction

  function automatic even_tab_t build_even_tab();
    even_tab_t t;
    for (int i = 0; i <= ACOS_DEPTH / 2; i++) begin
      t[i] = acos_entry(2 * i);
    end
    return t;
  endfunction

  function automatic odd_tab_t build_odd_tab();
    odd_tab_t t;
    for (int i = 0; i < ACOS_DEPTH / 2; i++) begin
      t[i] = acos_entry(2 * i + 1);
    end
    return t;
  endfunction

endpackage

### rtl/double_phase_hologram_pixel.sv
// Top level of the double-phase hologram pixel encoder.
//
//   Channel   Direction  Handshake                 Payload
//   pixel     in         pixel_valid/pixel_ready   phase_in, amplitude_in, start_of_frame
//   result    out        result_valid/result_ready hologram_phase, sum_arm, end_of_row
//   cfg       in         cfg_write                 cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; from acceptance to result_valid each item passes through
// arccosine table read, interpolation multiply, then rounding and the final add.
// The table is split into even and odd ROM banks so both neighbors are read at once.
// Reset clears position counters, pipeline valids and restores register defaults.
// A stalled result holds the whole pipeline; pixel_ready is low only then.
module double_phase_hologram_pixel (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  logic [dphp_pkg::PHASE_W-1:0]        phase_in,
  input  logic [dphp_pkg::AMP_W-1:0]          amplitude_in,
  input  logic                                start_of_frame,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [dphp_pkg::PHASE_W-1:0]        hologram_phase,
  output logic                                sum_arm,
  output logic                                end_of_row,
  input  logic                                cfg_write,
  input  logic [dphp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dphp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dphp_pkg::*;

  localparam even_tab_t EvenTab = build_even_tab();
  localparam odd_tab_t OddTab = build_odd_tab();

  logic [CELL_CFG_W-1:0] cell_size;
  logic [LEN_CFG_W-1:0]  row_length;

  logic [COL_W-1:0]  column_count;
  logic [CELL_W-1:0] column_in_cell;
  logic [CELL_W-1:0] row_in_cell;
  logic              column_cell_parity;
  logic              row_cell_parity;

  logic [COL_W-1:0]  column_count_next;
  logic [CELL_W-1:0] column_in_cell_next;
  logic [CELL_W-1:0] row_in_cell_next;
  logic              column_cell_parity_next;
  logic              row_cell_parity_next;

  logic                  advance;
  logic                  accept;
  logic [CELL_CFG_W-1:0] csz_eff;
  logic [CELL_W-1:0]     csz_m1;
  logic [LEN_CFG_W-1:0]  len_eff;
  logic [LEN_CFG_W-1:0]  len_m1;
  logic [COL_W-1:0]      cc_cur;
  logic [CELL_W-1:0]     cic_cur;
  logic [CELL_W-1:0]     ric_cur;
  logic                  ccp_cur;
  logic                  rcp_cur;
  logic                  arm_in;
  logic                  eor_in;

  logic [AMP_W-1:0]         amp_sat;
  logic [AMP_W+ACOS_AW-1:0] pos;
  logic [ACOS_AW:0]         idx;
  logic [ACOS_AW+1:0]       idx_p1;
  logic [ACOS_AW-1:0]       even_addr;
  logic [ACOS_AW-2:0]       odd_addr;

  logic              s1_valid;
  acos_val_t         s1_even;
  acos_val_t         s1_odd;
  logic              s1_swap;
  logic [FRAC_W-1:0] s1_frac;
  logic [PHASE_W-1:0] s1_base;
  logic              s1_arm;
  logic              s1_eor;

  acos_val_t lo;
  acos_val_t hi;
  logic      desc;
  acos_val_t diff;

  logic                     s2_valid;
  logic [ACOS_W+FRAC_W-1:0] s2_prod;
  acos_val_t                s2_lo;
  logic                     s2_desc;
  logic [PHASE_W-1:0]       s2_base;
  logic                     s2_arm;
  logic                     s2_eor;

  acos_val_t          step;
  acos_val_t          interp;
  logic [ACOS_W:0]    rounded;
  logic [PHASE_W-1:0] ac;
  logic [PHASE_W-1:0] result_next;

  assign advance = !result_valid || result_ready;
  assign pixel_ready = advance;
  assign accept = pixel_valid && advance;

  always_comb begin
    if (cell_size == '0) begin
      csz_eff = CELL_CFG_W'(1);
    end else if (cell_size > CELL_CFG_W'(MAX_CELL)) begin
      csz_eff = CELL_CFG_W'(MAX_CELL);
    end else begin
      csz_eff = cell_size;
    end
    csz_m1 = CELL_W'(csz_eff - CELL_CFG_W'(1));
    if (row_length < LEN_CFG_W'(2)) begin
      len_eff = LEN_CFG_W'(2);
    end else if (row_length > LEN_CFG_W'(MAX_ROW_LENGTH)) begin
      len_eff = LEN_CFG_W'(MAX_ROW_LENGTH);
    end else begin
      len_eff = row_length;
    end
    len_m1 = len_eff - LEN_CFG_W'(1);

    cc_cur  = start_of_frame ? '0 : column_count;
    cic_cur = start_of_frame ? '0 : column_in_cell;
    ric_cur = start_of_frame ? '0 : row_in_cell;
    ccp_cur = start_of_frame ? 1'b0 : column_cell_parity;
    rcp_cur = start_of_frame ? 1'b0 : row_cell_parity;

    arm_in = (ccp_cur == rcp_cur);
    eor_in = (LEN_CFG_W'(cc_cur) >= len_m1);

    column_count_next       = cc_cur;
    column_in_cell_next     = cic_cur;
    row_in_cell_next        = ric_cur;
    column_cell_parity_next = ccp_cur;
    row_cell_parity_next    = rcp_cur;
    if (eor_in) begin
      column_count_next       = '0;
      column_in_cell_next     = '0;
      column_cell_parity_next = 1'b0;
      if (ric_cur >= csz_m1) begin
        row_in_cell_next     = '0;
        row_cell_parity_next = !rcp_cur;
      end else begin
        row_in_cell_next = ric_cur + CELL_W'(1);
      end
    end else begin
      column_count_next = cc_cur + COL_W'(1);
      if (cic_cur >= csz_m1) begin
        column_in_cell_next     = '0;
        column_cell_parity_next = !ccp_cur;
      end else begin
        column_in_cell_next = cic_cur + CELL_W'(1);
      end
    end

    amp_sat   = (amplitude_in > AMP_ONE) ? AMP_ONE : amplitude_in;
    pos       = {amp_sat, {ACOS_AW{1'b0}}};
    idx       = pos[AMP_W+ACOS_AW-1:FRAC_W];
    idx_p1    = {1'b0, idx} + (ACOS_AW+2)'(1);
    even_addr = idx_p1[ACOS_AW:1];
    odd_addr  = idx[ACOS_AW-1:1];
  end

  always_comb begin
    lo   = s1_swap ? s1_odd : s1_even;
    hi   = s1_swap ? s1_even : s1_odd;
    desc = (lo >= hi);
    diff = desc ? (lo - hi) : (hi - lo);

    step    = s2_prod[ACOS_W+FRAC_W-1:FRAC_W];
    interp  = s2_desc ? (s2_lo - step) : (s2_lo + step);
    rounded = ({1'b0, interp} + (ACOS_W+1)'(128)) >> ROUND_SHIFT;
    if (rounded > (ACOS_W+1)'(QUARTER_TURN_16)) begin
      ac = QUARTER_TURN_16;
    end else begin
      ac = rounded[PHASE_W-1:0];
    end
    result_next = s2_arm ? (s2_base + ac) : (s2_base - ac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size          <= CELL_CFG_W'(1);
      row_length         <= LEN_CFG_W'(1920);
      column_count       <= '0;
      column_in_cell     <= '0;
      row_in_cell        <= '0;
      column_cell_parity <= 1'b0;
      row_cell_parity    <= 1'b0;
      s1_valid           <= 1'b0;
      s2_valid           <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CELL_SIZE:  cell_size <= cfg_data[CELL_CFG_W-1:0];
          REG_ROW_LENGTH: row_length <= cfg_data[LEN_CFG_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        column_count       <= column_count_next;
        column_in_cell     <= column_in_cell_next;
        row_in_cell        <= row_in_cell_next;
        column_cell_parity <= column_cell_parity_next;
        row_cell_parity    <= row_cell_parity_next;
      end
      if (advance) begin
        s1_valid     <= pixel_valid;
        s2_valid     <= s1_valid;
        result_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_even <= EvenTab[even_addr];
      s1_odd  <= OddTab[odd_addr];
      s1_swap <= idx[0];
      s1_frac <= pos[FRAC_W-1:0];
      s1_base <= phase_in + HALF_TURN;
      s1_arm  <= arm_in;
      s1_eor  <= eor_in;

      s2_prod <= diff * s1_frac;
      s2_lo   <= lo;
      s2_desc <= desc;
      s2_base <= s1_base;
      s2_arm  <= s1_arm;
      s2_eor  <= s1_eor;

      hologram_phase <= result_next;
      sum_arm        <= s2_arm;
      end_of_row     <= s2_eor;
    end
  end

endmodule

### rtl/dphp_checker.sv
// Port-level checker for the double-phase hologram pixel encoder, bound to the top level.
module dphp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         pixel_valid,
  input logic                         pixel_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [dphp_pkg::PHASE_W-1:0] hologram_phase,
  input logic                         sum_arm,
  input logic                         end_of_row
);
  import dphp_pkg::*;

  // A result that is not taken stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(hologram_phase) && $stable(sum_arm) && $stable(end_of_row))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result item offered after reset");

  // The block only refuses pixels while a result waits.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid || result_ready |-> pixel_ready)
    else $error("pixel refused with a free output");

  // A stalled output stalls the input side too.
  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !pixel_ready)
    else $error("pixel accepted while output stalled");

endmodule

bind double_phase_hologram_pixel dphp_checker u_dphp_checker (.*);
